// ===== design/dq_pkg.sv =====
// dq_pkg: shared types and constants for the double-ended queue core
// holds command/status codes, beat payload structs and the control bundle
// no dependencies
package dq_pkg;

  localparam int VALUE_W = 32;
  localparam int OCC_W   = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } dq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef struct packed {
    dq_op_t                     cmd;
    logic signed [VALUE_W-1:0]  push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  result_value;
    dq_status_t                 status;
    logic [OCC_W-1:0]           occupancy;
  } dq_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture command, work out address and status
    logic rd_en;   // read the store at the captured address
    logic commit;  // write back, update pointers, load result register
  } dq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic pop_ok;  // captured command is a pop that will succeed
  } dq_sts_t;

endpackage

// ===== design/dq_ram.sv =====
// dq_ram: generic single write port, single read port ram
// read data is registered; no reset on contents
// no dependencies
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/dq_datapath.sv =====
// dq_datapath: ring pointers, occupancy count, entry store and result register
// depends on dq_pkg and dq_ram
// driven by dq_ctrl through dq_ctl_t
module dq_datapath import dq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  dq_in_t  cmd_beat,
  input  dq_ctl_t ctl,
  output dq_sts_t sts,
  output dq_out_t res_beat
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]   front_index;
  logic [CNT_W-1:0]   entry_count;
  logic [IDX_W-1:0]   front_index_next;
  logic [CNT_W-1:0]   entry_count_next;

  dq_op_t             op;
  logic [VALUE_W-1:0] value;
  logic [IDX_W-1:0]   addr;
  dq_status_t         status;
  logic [IDX_W-1:0]   addr_next;
  dq_status_t         status_next;

  logic               is_push;
  logic               full;
  logic               empty;
  logic [CNT_W:0]     rear_wr_sum;
  logic [CNT_W:0]     rear_rd_sum;
  logic [IDX_W-1:0]   rear_wr_addr;
  logic [IDX_W-1:0]   rear_rd_addr;
  logic [IDX_W-1:0]   front_dec;
  logic [IDX_W-1:0]   front_inc;
  logic [CNT_W-1:0]   count_m1;

  logic               ram_wr_en;
  logic [VALUE_W-1:0] rd_data;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  // pointer arithmetic: ring wraparound by compare and subtract for the front and rear addresses
  always_comb begin
    is_push     = (cmd_beat.cmd == OP_PUSH_FRONT) || (cmd_beat.cmd == OP_PUSH_REAR);
    full        = (entry_count == CNT_W'(DEPTH));
    empty       = (entry_count == '0);
    count_m1    = entry_count - 1'b1;
    front_dec   = (front_index == '0) ? IDX_W'(DEPTH - 1) : front_index - 1'b1;
    front_inc   = (front_index == IDX_W'(DEPTH - 1)) ? '0 : front_index + 1'b1;
    rear_wr_sum = (CNT_W+1)'(front_index) + (CNT_W+1)'(entry_count);
    rear_rd_sum = (CNT_W+1)'(front_index) + (CNT_W+1)'(count_m1);
    rear_wr_addr = (rear_wr_sum >= (CNT_W+1)'(DEPTH))
                 ? IDX_W'(rear_wr_sum - (CNT_W+1)'(DEPTH)) : IDX_W'(rear_wr_sum);
    rear_rd_addr = (rear_rd_sum >= (CNT_W+1)'(DEPTH))
                 ? IDX_W'(rear_rd_sum - (CNT_W+1)'(DEPTH)) : IDX_W'(rear_rd_sum);

    if (is_push) begin
      status_next = full ? ST_FULL : ST_OK;
    end else begin
      status_next = empty ? ST_EMPTY : ST_OK;
    end

    case (cmd_beat.cmd)
      OP_PUSH_FRONT: addr_next = front_dec;
      OP_PUSH_REAR:  addr_next = rear_wr_addr;
      OP_POP_FRONT:  addr_next = front_index;
      OP_POP_REAR:   addr_next = rear_rd_addr;
      default:       addr_next = front_index;
    endcase
  end

  assign sts.pop_ok = (status == ST_OK) && ((op == OP_POP_FRONT) || (op == OP_POP_REAR));

  // state update applied at commit
  always_comb begin
    front_index_next = front_index;
    entry_count_next = entry_count;
    ram_wr_en        = 1'b0;
    if (status == ST_OK) begin
      case (op)
        OP_PUSH_FRONT: begin
          front_index_next = addr;
          entry_count_next = entry_count + 1'b1;
          ram_wr_en        = ctl.commit;
        end
        OP_PUSH_REAR: begin
          entry_count_next = entry_count + 1'b1;
          ram_wr_en        = ctl.commit;
        end
        OP_POP_FRONT: begin
          front_index_next = front_inc;
          entry_count_next = entry_count - 1'b1;
        end
        OP_POP_REAR: begin
          entry_count_next = entry_count - 1'b1;
        end
        default: begin
          entry_count_next = entry_count;
        end
      endcase
    end
  end

  assign occ_ext = (CNT_W+OCC_W)'(entry_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      entry_count <= '0;
    end else if (ctl.commit) begin
      front_index <= front_index_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op     <= cmd_beat.cmd;
      value  <= cmd_beat.push_value;
      addr   <= addr_next;
      status <= status_next;
    end
    if (ctl.commit) begin
      res_beat.status    <= status;
      res_beat.occupancy <= occ_ext[OCC_W-1:0];
      if (status != ST_OK) begin
        res_beat.result_value <= '0;
      end else if (sts.pop_ok) begin
        res_beat.result_value <= rd_data;
      end else begin
        res_beat.result_value <= value;
      end
    end
  end

  dq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (addr),
    .wr_data (value),
    .rd_en   (ctl.rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front_index <= IDX_W'(DEPTH - 1))
    else $error("front index outside ring");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && sts.pop_ok |-> entry_count != '0)
    else $error("pop committed on empty ring");

endmodule

// ===== design/dq_ctrl.sv =====
// dq_ctrl: command sequencer for the double-ended queue core
// steps one command through capture, store read and commit
// depends on dq_pkg
module dq_ctrl import dq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_stall,
  output logic    res_valid,
  input  logic    res_stall,
  input  dq_sts_t sts,
  output dq_ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !res_valid || !res_stall;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    ctl.load   = (state == S_IDLE) && cmd_valid;
    ctl.rd_en  = (state == S_READ) && sts.pop_ok;
    ctl.commit = (state == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> (!res_valid || !res_stall))
    else $error("result register overwritten");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(ctl.commit))
    else $error("result beat without commit");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> !ctl.load ##1 !ctl.load)
    else $error("command taken while one in flight");

endmodule

// ===== design/double_ended_queue_core.sv =====
// double_ended_queue_core: deque of signed 32-bit words in a ring of DEPTH entries
// each command is captured, its store read, then the result register loaded
// a new command is taken only after the last one commits (capture, store read, commit),
//   later while the result register is stalled
// reset: rst (sync, active high) empties the deque; store contents are not cleared
// depends on dq_pkg, dq_ctrl, dq_datapath, dq_ram
module double_ended_queue_core import dq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  // command beats
  input  logic    cmd_valid,
  output logic    cmd_stall,
  input  dq_in_t  cmd_beat,
  // result beats, one per command
  output logic    res_valid,
  input  logic    res_stall,
  output dq_out_t res_beat
);

  // command and status bundle between sequencer and datapath
  dq_ctl_t ctl;
  dq_sts_t sts;

  // sequencer: idle -> read -> done; done waits for a free result register,
  // so a pending result beat can sit at the output while the next command
  // is captured and its store read is done
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // datapath: front index and count registers, ring address math,
  // entry store with registered read, result register
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd_beat (cmd_beat),
    .ctl      (ctl),
    .sts      (sts),
    .res_beat (res_beat)
  );

endmodule
